[rtl/thermt_pkg.sv]
package thermt_pkg;

  // table geometry
  localparam int ROM_SIZE  = 34;
  localparam int ROM_IDX_W = 6;
  localparam int ROM_W     = 18;

  // temperature scale, 1/256 degree units
  localparam int TEMP_BASE = -10240;
  localparam int TEMP_STEP = 1280;

  // reference resistor register
  localparam int          RREF_W     = 20;
  localparam logic [19:0] RREF_RESET = 20'd10000;

  // range status codes
  localparam logic [1:0] ST_IN_RANGE  = 2'd0;
  localparam logic [1:0] ST_COLD      = 2'd1;
  localparam logic [1:0] ST_HOT       = 2'd2;
  localparam logic [1:0] ST_CODE_ZERO = 2'd3;

  // thermistor resistance in ohms, one point every 5 degrees from -40
  function automatic logic [ROM_W-1:0] rom_ohms(input logic [ROM_IDX_W-1:0] i);
    case (i)
      6'd0:    rom_ohms = 18'd195652;
      6'd1:    rom_ohms = 18'd148171;
      6'd2:    rom_ohms = 18'd113347;
      6'd3:    rom_ohms = 18'd87559;
      6'd4:    rom_ohms = 18'd68237;
      6'd5:    rom_ohms = 18'd53650;
      6'd6:    rom_ohms = 18'd42506;
      6'd7:    rom_ohms = 18'd33892;
      6'd8:    rom_ohms = 18'd27219;
      6'd9:    rom_ohms = 18'd22021;
      6'd10:   rom_ohms = 18'd17926;
      6'd11:   rom_ohms = 18'd14674;
      6'd12:   rom_ohms = 18'd12081;
      6'd13:   rom_ohms = 18'd10000;
      6'd14:   rom_ohms = 18'd8315;
      6'd15:   rom_ohms = 18'd6948;
      6'd16:   rom_ohms = 18'd5834;
      6'd17:   rom_ohms = 18'd4917;
      6'd18:   rom_ohms = 18'd4161;
      6'd19:   rom_ohms = 18'd3535;
      6'd20:   rom_ohms = 18'd3014;
      6'd21:   rom_ohms = 18'd2586;
      6'd22:   rom_ohms = 18'd2228;
      6'd23:   rom_ohms = 18'd1925;
      6'd24:   rom_ohms = 18'd1669;
      6'd25:   rom_ohms = 18'd1452;
      6'd26:   rom_ohms = 18'd1268;
      6'd27:   rom_ohms = 18'd1110;
      6'd28:   rom_ohms = 18'd974;
      6'd29:   rom_ohms = 18'd858;
      6'd30:   rom_ohms = 18'd758;
      6'd31:   rom_ohms = 18'd672;
      6'd32:   rom_ohms = 18'd596;
      6'd33:   rom_ohms = 18'd531;
      default: rom_ohms = 18'd0;
    endcase
  endfunction

  // temperature of table point i
  function automatic logic signed [15:0] point_temp(input logic [ROM_IDX_W-1:0] i);
    point_temp = 16'(TEMP_BASE + TEMP_STEP * int'(i));
  endfunction

endpackage

[rtl/thermt_div.sv]
module thermt_div #(
  parameter int DW  = 33,
  parameter int DVW = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [DW-1:0]  dividend,
  input  logic [DVW-1:0] divisor,
  output logic           done,
  output logic [DW-1:0]  quotient
);

  localparam int CNW = $clog2(DW + 1);

  logic           busy;
  logic [CNW-1:0] cnt;
  logic [DW-1:0]  dvd;
  logic [DVW-1:0] dvs;
  logic [DVW-1:0] rem;
  logic [DVW:0]   shifted;
  logic [DVW:0]   trial;
  logic           ge;

  // one restoring step
  always_comb begin
    shifted = {rem, dvd[DW-1]};
    trial   = shifted - {1'b0, dvs};
    ge      = shifted >= {1'b0, dvs};
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNW'(DW);
      end else if (busy) begin
        cnt <= cnt - CNW'(1);
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // datapath, quotient bits shift in behind the dividend
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? trial[DVW-1:0] : shifted[DVW-1:0];
      dvd <= {dvd[DW-2:0], ge};
    end
  end

  assign quotient = dvd;

endmodule

[rtl/thermistor_adc_to_temperature_unit.sv]
// Thermistor ADC code to temperature.
// Input channel: in_valid / in_stall carrying one 12-bit adc_code word.
// Output channel: out_valid / out_stall carrying temperature (signed 1/256 C),
// resistance_ohms (saturating) and range_status for each input word.
// Configuration: cfg_write with cfg_data loads the reference resistor in ohms.
// One shared restoring divider, one quotient bit per cycle, computes first the
// resistance and then the interpolation fraction; a sequencer scans the table
// one point per cycle between the two divisions.
// Code zero skips both divisions and the table scan. Divider width is
// DW = max(20 + clog2(ADC_FULL_SCALE+1), 27). One word is in flight at a
// time, so in_stall is high from accept until the result moves to the
// output register.
// The output register holds a result while out_stall is high; a new word may
// be accepted then, and its result waits in the sequencer until the slot frees.
// Reset clears out_valid and the sequencer, and sets the resistor to 10000 ohms.
module thermistor_adc_to_temperature_unit
  import thermt_pkg::*;
#(
  parameter int TABLE_POINTS   = 34,
  parameter int ADC_FULL_SCALE = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [19:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [11:0]        adc_code,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] temperature,
  output logic [31:0]        resistance_ohms,
  output logic [1:0]         range_status
);

  localparam int N_CAP  = (TABLE_POINTS > ROM_SIZE) ? ROM_SIZE : TABLE_POINTS;
  localparam int N_USED = (N_CAP < 2) ? 2 : N_CAP;
  localparam int DFW    = $clog2(ADC_FULL_SCALE + 1);
  localparam int PW     = RREF_W + DFW;
  localparam int DW     = (PW > 27) ? PW : 27;
  localparam int DVW    = 16;
  localparam int QW     = (DW > 32) ? DW : 33;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MUL   = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_WAIT1 = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_DIV2  = 3'd5;
  localparam logic [2:0] S_WAIT2 = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]           state;
  logic [RREF_W-1:0]    r_ref;
  logic [11:0]          code;
  logic [PW-1:0]        prod;
  logic [31:0]          res;
  logic [ROM_IDX_W-1:0] k;
  logic [26:0]          num;
  logic [DVW-1:0]       dsub;
  logic signed [15:0]   temp;
  logic [1:0]           status;

  logic [16:0]          fs_w;
  logic [16:0]          code_w;
  logic [16:0]          diff_w;
  logic                 div_start;
  logic [DW-1:0]        div_dividend;
  logic [DVW-1:0]       div_divisor;
  logic                 div_done;
  logic [DW-1:0]        div_quot;
  logic [QW-1:0]        quot_ext;
  logic [ROM_W-1:0]     rom_k;
  logic [ROM_W-1:0]     rom_prev;
  logic [ROM_W-1:0]     x;
  logic [ROM_W-1:0]     d_full;
  logic [26:0]          num_next;
  logic                 res_ge;
  logic                 out_free;

  // reference resistor register
  always_ff @(posedge clk) begin
    if (rst) begin
      r_ref <= RREF_RESET;
    end else if (cfg_write) begin
      r_ref <= cfg_data;
    end
  end

  // full scale minus code, zero when the code reaches full scale
  always_comb begin
    fs_w   = 17'(ADC_FULL_SCALE);
    code_w = 17'(code);
    diff_w = (fs_w > code_w) ? (fs_w - code_w) : 17'd0;
  end

  // divider operand select
  always_comb begin
    div_start = (state == S_DIV1) || (state == S_DIV2);
    if (state == S_DIV2) begin
      div_dividend = DW'(num);
      div_divisor  = dsub;
    end else begin
      div_dividend = DW'(prod);
      div_divisor  = DVW'(code);
    end
  end

  thermt_div #(
    .DW  (DW),
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quot)
  );

  // table scan and interpolation operands
  always_comb begin
    quot_ext = QW'(div_quot);
    rom_k    = rom_ohms(k);
    rom_prev = rom_ohms(k - ROM_IDX_W'(1));
    res_ge   = res >= 32'(rom_k);
    x        = rom_prev - res[ROM_W-1:0];
    d_full   = rom_prev - rom_k;
    num_next = 27'({x, 10'b0}) + 27'({x, 8'b0}) + 27'(d_full[ROM_W-1:1]);
  end

  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= (adc_code == 12'd0) ? S_OUT : S_MUL;
          end
        end
        S_MUL:   state <= S_DIV1;
        S_DIV1:  state <= S_WAIT1;
        S_WAIT1: begin
          if (div_done) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (res_ge) begin
            state <= (k == '0) ? S_OUT : S_DIV2;
          end else if (k == ROM_IDX_W'(N_USED - 1)) begin
            state <= S_OUT;
          end
        end
        S_DIV2:  state <= S_WAIT2;
        S_WAIT2: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        code <= adc_code;
        k    <= '0;
        res    <= 32'hFFFF_FFFF;
        temp   <= point_temp('0);
        status <= ST_CODE_ZERO;
      end
      S_MUL: begin
        prod <= PW'(r_ref) * PW'(diff_w[DFW-1:0]);
      end
      S_WAIT1: begin
        res <= (|quot_ext[QW-1:32]) ? 32'hFFFF_FFFF : quot_ext[31:0];
      end
      S_SCAN: begin
        if (res_ge) begin
          if (k == '0) begin
            temp   <= point_temp('0);
            status <= (res == 32'(rom_k)) ? ST_IN_RANGE : ST_COLD;
          end else begin
            num  <= num_next;
            dsub <= d_full[DVW-1:0];
          end
        end else if (k == ROM_IDX_W'(N_USED - 1)) begin
          temp   <= point_temp(k);
          status <= ST_HOT;
        end else begin
          k <= k + ROM_IDX_W'(1);
        end
      end
      S_WAIT2: begin
        temp   <= point_temp(k - ROM_IDX_W'(1)) + signed'(16'(div_quot));
        status <= ST_IN_RANGE;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      temperature     <= temp;
      resistance_ohms <= res;
      range_status    <= status;
    end
  end

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state != S_IDLE)
    else $error("accepted word did not start the sequencer");

  a_scan_in_table: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> k < ROM_IDX_W'(N_USED))
    else $error("table scan ran past the last point");

  a_code_zero_res: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_status == ST_CODE_ZERO |-> resistance_ohms == 32'hFFFF_FFFF)
    else $error("code zero without saturated resistance");

  a_cold_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && (range_status == ST_COLD || range_status == ST_CODE_ZERO)
    |-> temperature == 16'(TEMP_BASE))
    else $error("cold clamp temperature wrong");

  a_in_range_temp: assert property (@(posedge clk) disable iff (rst)
    out_valid && range_status == ST_IN_RANGE
    |-> temperature >= 16'(TEMP_BASE) &&
        temperature <= point_temp(ROM_IDX_W'(N_USED - 1)))
    else $error("interpolated temperature outside the table");
`endif

endmodule
